@@ design/kwlex_pkg.sv @@
`timescale 1ns / 1ps

package kwlex_pkg;

   localparam int MAX_LINE_LENGTH = 1024;
   localparam int COL_CAP_INT     = (MAX_LINE_LENGTH - 1 < 1023) ? MAX_LINE_LENGTH - 1 : 1023;
   localparam logic [9:0]  COL_CAP  = 10'(COL_CAP_INT);
   localparam logic [9:0]  LEN_MAX  = 10'h3FF;
   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   localparam logic [4:0] KIND_END    = 5'd0;
   localparam logic [4:0] KIND_SEMI   = 5'd1;
   localparam logic [4:0] KIND_PLUS   = 5'd2;
   localparam logic [4:0] KIND_MINUS  = 5'd3;
   localparam logic [4:0] KIND_STAR   = 5'd4;
   localparam logic [4:0] KIND_SLASH  = 5'd5;
   localparam logic [4:0] KIND_LPAREN = 5'd6;
   localparam logic [4:0] KIND_RPAREN = 5'd7;
   localparam logic [4:0] KIND_LESS   = 5'd8;
   localparam logic [4:0] KIND_GREAT  = 5'd9;
   localparam logic [4:0] KIND_EQUAL  = 5'd10;
   localparam logic [4:0] KIND_ASSIGN = 5'd11;
   localparam logic [4:0] KIND_IF     = 5'd12;
   localparam logic [4:0] KIND_THEN   = 5'd13;
   localparam logic [4:0] KIND_WHILE  = 5'd14;
   localparam logic [4:0] KIND_DO     = 5'd15;
   localparam logic [4:0] KIND_BEGIN  = 5'd16;
   localparam logic [4:0] KIND_ENDKW  = 5'd17;
   localparam logic [4:0] KIND_IDENT  = 5'd18;
   localparam logic [4:0] KIND_NUMBER = 5'd19;
   localparam logic [4:0] KIND_ERROR  = 5'd20;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GREAT  = 8'h3E;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

   typedef enum logic [3:0] {
      PEND_NONE  = 4'b0001,
      PEND_IDENT = 4'b0010,
      PEND_NUM   = 4'b0100,
      PEND_COLON = 4'b1000
   } pend_type;

   typedef struct packed {
      logic        last;
      logic [9:0]  column;
      logic [15:0] line;
      logic [9:0]  length;
      logic [4:0]  kind;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic logic [4:0] op_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         CH_SEMI:   k = KIND_SEMI;
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_SLASH:  k = KIND_SLASH;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_LESS:   k = KIND_LESS;
         CH_GREAT:  k = KIND_GREAT;
         CH_EQUAL:  k = KIND_EQUAL;
         default:   k = KIND_END;
      endcase
      return k;
   endfunction

   // Keyword prefix tree: each keyword owns a run of nodes, one per character matched.
   function automatic logic [4:0] kw_start(input logic [7:0] c);
      logic [4:0] n;
      case (c)
         8'h69:   n = 5'd1;
         8'h74:   n = 5'd3;
         8'h77:   n = 5'd7;
         8'h64:   n = 5'd12;
         8'h62:   n = 5'd14;
         8'h65:   n = 5'd19;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

   // Character that extends the prefix at this node; zero where no extension exists.
   function automatic logic [7:0] kw_expect(input logic [4:0] node);
      logic [7:0] c;
      case (node)
         5'd1:    c = 8'h66;
         5'd3:    c = 8'h68;
         5'd4:    c = 8'h65;
         5'd5:    c = 8'h6E;
         5'd7:    c = 8'h68;
         5'd8:    c = 8'h69;
         5'd9:    c = 8'h6C;
         5'd10:   c = 8'h65;
         5'd12:   c = 8'h6F;
         5'd14:   c = 8'h65;
         5'd15:   c = 8'h67;
         5'd16:   c = 8'h69;
         5'd17:   c = 8'h6E;
         5'd19:   c = 8'h6E;
         5'd20:   c = 8'h64;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [4:0] kw_next(input logic [4:0] node, input logic [7:0] c);
      logic [7:0] e;
      e = kw_expect(node);
      return (e != 8'h00 && c == e) ? node + 5'd1 : 5'd0;
   endfunction

   function automatic logic [4:0] id_kind(input logic [4:0] node);
      logic [4:0] k;
      case (node)
         5'd2:    k = KIND_IF;
         5'd6:    k = KIND_THEN;
         5'd11:   k = KIND_WHILE;
         5'd13:   k = KIND_DO;
         5'd18:   k = KIND_BEGIN;
         5'd21:   k = KIND_ENDKW;
         default: k = KIND_IDENT;
      endcase
      return k;
   endfunction

endpackage

@@ design/kwlex_rsp_fifo.sv @@
`timescale 1ns / 1ps

module kwlex_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  kwlex_pkg::push_type  push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kwlex_pkg::token_type rsp_token
);

   kwlex_pkg::token_type                  entry_ff [kwlex_pkg::FIFO_DEPTH];
   logic [kwlex_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [kwlex_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [kwlex_pkg::FIFO_CNT_W-1:0]      count_ff, count_in;
   logic [kwlex_pkg::FIFO_PTR_W-1:0]      wr_ptr_next;
   logic                                  pop;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = count_ff != '0;
   assign rsp_token   = entry_ff[rd_ptr_ff];
   assign room        = count_ff <= kwlex_pkg::FIFO_CNT_W'(kwlex_pkg::FIFO_DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + kwlex_pkg::FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + kwlex_pkg::FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + kwlex_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + kwlex_pkg::FIFO_CNT_W'(push.count)
                  - kwlex_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kwlex_pkg::FIFO_CNT_W'(kwlex_pkg::FIFO_DEPTH))
      else $error("response queue holds more beats than its depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("response queue count did not drop after a beat left");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("response queue took beats without room for them");
`endif

endmodule

@@ design/keyword_token_lexer.sv @@
`timescale 1ns / 1ps

// A byte beat is registered at the input; its token beats leave through the token queue.
// Throughput: one byte beat per cycle while the queue has room; a byte that closes a
// pending token and makes one of its own gives two token beats, and the four-entry token
// queue paces the input then. Reset (synchronous) clears the pending token, the queue,
// sets the line count to one and the column to zero.
module keyword_token_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // text_byte
   input  logic        req_tlast,  // end_mark
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // token_kind, token_length, line_number, start_column
   output logic        rsp_tlast   // last_of_run
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_end_ff;
   kwlex_pkg::pend_type  class_ff, class_in;
   logic [4:0]           node_ff, node_in;
   logic [9:0]           len_ff, len_in;
   logic [9:0]           start_ff, start_in;
   logic [9:0]           col_ff, col_in;
   logic [15:0]          line_ff, line_in;

   logic                 room;
   logic                 fire;
   kwlex_pkg::push_type  push;
   kwlex_pkg::token_type pend_tok, byte_tok, head;
   logic                 pend_valid, pend_emit, byte_valid;
   logic [9:0]           col_inc, len_inc;
   logic [4:0]           op;

   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   assign col_inc = (col_ff < kwlex_pkg::COL_CAP) ? col_ff + 10'd1 : col_ff;
   assign len_inc = (len_ff < kwlex_pkg::LEN_MAX) ? len_ff + 10'd1 : len_ff;
   assign op      = kwlex_pkg::op_kind(in_byte_ff);

   always_comb begin
      pend_tok        = '0;
      pend_tok.line   = line_ff;
      pend_tok.column = start_ff;
      pend_tok.length = len_ff;
      pend_valid      = 1'b1;
      unique case (class_ff)
         kwlex_pkg::PEND_IDENT: pend_tok.kind = kwlex_pkg::id_kind(node_ff);
         kwlex_pkg::PEND_NUM:   pend_tok.kind = kwlex_pkg::KIND_NUMBER;
         kwlex_pkg::PEND_COLON: begin
            pend_tok.kind   = kwlex_pkg::KIND_ERROR;
            pend_tok.length = 10'd1;
         end
         default: pend_valid = 1'b0;
      endcase
   end

   always_comb begin
      class_in    = class_ff;
      node_in     = node_ff;
      len_in      = len_ff;
      start_in    = start_ff;
      col_in      = col_ff;
      line_in     = line_ff;
      byte_tok    = '0;
      byte_tok.line   = line_ff;
      byte_tok.column = col_ff;
      byte_tok.length = 10'd1;
      byte_valid  = 1'b0;
      pend_emit   = pend_valid;
      push        = '0;

      if (in_end_ff) begin
         byte_tok.kind   = kwlex_pkg::KIND_END;
         byte_tok.length = 10'd0;
         byte_valid      = 1'b1;
         class_in        = kwlex_pkg::PEND_NONE;
         node_in         = 5'd0;
         len_in          = 10'd0;
      end else if (class_ff == kwlex_pkg::PEND_IDENT &&
                   (kwlex_pkg::is_letter(in_byte_ff) || kwlex_pkg::is_digit(in_byte_ff))) begin
         node_in    = kwlex_pkg::kw_next(node_ff, in_byte_ff);
         len_in     = len_inc;
         col_in     = col_inc;
         pend_emit  = 1'b0;
      end else if (class_ff == kwlex_pkg::PEND_NUM && kwlex_pkg::is_digit(in_byte_ff)) begin
         len_in     = len_inc;
         col_in     = col_inc;
         pend_emit  = 1'b0;
      end else if (class_ff == kwlex_pkg::PEND_COLON && in_byte_ff == kwlex_pkg::CH_EQUAL) begin
         byte_tok.kind   = kwlex_pkg::KIND_ASSIGN;
         byte_tok.length = 10'd2;
         byte_tok.column = start_ff;
         byte_valid      = 1'b1;
         pend_emit       = 1'b0;
         class_in        = kwlex_pkg::PEND_NONE;
         len_in          = 10'd0;
         col_in          = col_inc;
      end else begin
         class_in = kwlex_pkg::PEND_NONE;
         node_in  = 5'd0;
         len_in   = 10'd0;
         if (in_byte_ff == kwlex_pkg::CH_LF) begin
            line_in = (line_ff != kwlex_pkg::LINE_MAX) ? line_ff + 16'd1 : line_ff;
            col_in  = 10'd0;
         end else begin
            col_in = col_inc;
            if (in_byte_ff == kwlex_pkg::CH_SPACE || in_byte_ff == kwlex_pkg::CH_TAB) begin
               byte_valid = 1'b0;
            end else if (op != kwlex_pkg::KIND_END) begin
               byte_tok.kind = op;
               byte_valid    = 1'b1;
            end else if (in_byte_ff == kwlex_pkg::CH_COLON) begin
               class_in = kwlex_pkg::PEND_COLON;
               len_in   = 10'd1;
               start_in = col_ff;
            end else if (kwlex_pkg::is_letter(in_byte_ff)) begin
               class_in = kwlex_pkg::PEND_IDENT;
               len_in   = 10'd1;
               start_in = col_ff;
               node_in  = kwlex_pkg::kw_start(in_byte_ff);
            end else if (kwlex_pkg::is_digit(in_byte_ff)) begin
               class_in = kwlex_pkg::PEND_NUM;
               len_in   = 10'd1;
               start_in = col_ff;
            end else begin
               byte_tok.kind = kwlex_pkg::KIND_ERROR;
               byte_valid    = 1'b1;
            end
         end
      end

      byte_tok.last = 1'b1;
      if (pend_emit && byte_valid) begin
         push.count  = 2'd2;
         push.first  = pend_tok;
         push.second = byte_tok;
      end else if (pend_emit) begin
         push.count      = 2'd1;
         push.first      = pend_tok;
         push.first.last = 1'b1;
      end else if (byte_valid) begin
         push.count = 2'd1;
         push.first = byte_tok;
      end

      if (!fire) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff <= kwlex_pkg::PEND_NONE;
         node_ff  <= 5'd0;
         len_ff   <= 10'd0;
         start_ff <= 10'd0;
         col_ff   <= 10'd0;
         line_ff  <= 16'd1;
      end else if (fire) begin
         class_ff <= class_in;
         node_ff  <= node_in;
         len_ff   <= len_in;
         start_ff <= start_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
      end
   end

   kwlex_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_token (head)
   );

   assign rsp_tdata = {7'd0, head.column, head.line, head.length, head.kind};
   assign rsp_tlast = head.last;

`ifndef ASSERT_OFF
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (fire && in_end_ff) |->
         ((push.count == 2'd1 && push.first.kind == kwlex_pkg::KIND_END) ||
          (push.count == 2'd2 && push.second.kind == kwlex_pkg::KIND_END)))
      else $error("end of input did not finish with an end token");

   a_newline_counts: assert property (@(posedge clock) disable iff (reset)
      (fire && !in_end_ff && in_byte_ff == kwlex_pkg::CH_LF &&
       line_ff != kwlex_pkg::LINE_MAX) |=> line_ff == $past(line_ff) + 16'd1)
      else $error("newline beat did not advance the line count");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("token beat changed while it waited");
`endif

endmodule
